// ----- design/dmp_pkg.sv -----
package dmp_pkg;

    // Header length in bytes and the byte that ends a question name.
    localparam logic [3:0] HEADER_BYTES = 4'd12;
    localparam logic [7:0] NAME_END     = 8'h00;

    // Configuration register indexes and reset values.
    localparam logic        CFG_MAX_QUESTIONS = 1'b0;
    localparam logic        CFG_MAX_RECORDS   = 1'b1;
    localparam logic [15:0] MAX_COUNT_RESET   = 16'd64;

    // Field kinds.
    localparam logic [3:0] KIND_ID        = 4'd0;
    localparam logic [3:0] KIND_FLAGS     = 4'd1;
    localparam logic [3:0] KIND_QDCOUNT   = 4'd2;
    localparam logic [3:0] KIND_ANCOUNT   = 4'd3;
    localparam logic [3:0] KIND_NSCOUNT   = 4'd4;
    localparam logic [3:0] KIND_ARCOUNT   = 4'd5;
    localparam logic [3:0] KIND_NAME_BYTE = 4'd6;
    localparam logic [3:0] KIND_QTYPE     = 4'd7;
    localparam logic [3:0] KIND_QCLASS    = 4'd8;
    localparam logic [3:0] KIND_RNAME     = 4'd9;
    localparam logic [3:0] KIND_RTYPE     = 4'd10;
    localparam logic [3:0] KIND_RCLASS    = 4'd11;
    localparam logic [3:0] KIND_RTTL      = 4'd12;
    localparam logic [3:0] KIND_RDLEN     = 4'd13;
    localparam logic [3:0] KIND_DATA_BYTE = 4'd14;

    // Sections.
    localparam logic [1:0] SEC_QUESTION   = 2'd0;
    localparam logic [1:0] SEC_ANSWER     = 2'd1;
    localparam logic [1:0] SEC_AUTHORITY  = 2'd2;
    localparam logic [1:0] SEC_ADDITIONAL = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK             = 3'd0;
    localparam logic [2:0] ST_QUESTION_LIMIT = 3'd1;
    localparam logic [2:0] ST_ANSWER_LIMIT   = 3'd2;
    localparam logic [2:0] ST_AUTH_LIMIT     = 3'd3;
    localparam logic [2:0] ST_ADDL_LIMIT     = 3'd4;
    localparam logic [2:0] ST_TRUNCATED      = 3'd5;

    // One parse result, with a flag telling whether the byte produced one.
    typedef struct packed {
        logic        have;
        logic [3:0]  field_kind;
        logic [1:0]  section;
        logic [15:0] item_index;
        logic [31:0] field_value;
        logic [2:0]  status;
        logic        message_done;
    } t_result;

endpackage

// ----- design/dmp_parse_core.sv -----
module dmp_parse_core
    import dmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_max_questions,
    input  logic [15:0] i_max_records,
    output t_result     o_result
);

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QTYPE  = 4'd2,
        PH_QCLASS = 4'd3,
        PH_RNAME  = 4'd4,
        PH_RTYPE  = 4'd5,
        PH_RCLASS = 4'd6,
        PH_RTTL   = 4'd7,
        PH_RDLEN  = 4'd8,
        PH_RDATA  = 4'd9
    } t_phase;

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_cnt,       n_cnt;
    logic [23:0] r_shift,     n_shift;
    logic [15:0] r_q_left,    n_q_left;
    logic [15:0] r_an_left,   n_an_left;
    logic [15:0] r_ns_left,   n_ns_left;
    logic [15:0] r_ar_left,   n_ar_left;
    logic [15:0] r_data_left, n_data_left;
    logic [15:0] r_rec_idx,   n_rec_idx;
    logic        r_ended,     n_ended;

    logic [31:0] assembled;
    logic [1:0]  sec_cur;
    logic [2:0]  need;
    logic        do_next;
    logic        do_rec_done;
    logic        do_restart;
    logic [15:0] rec_left_dec;
    t_result     res;

    // The new byte shifted in behind the bytes already gathered.
    assign assembled = {r_shift, i_data_byte};
    assign need      = (r_phase == PH_RTTL) ? 3'd4 : 3'd2;

    // A record belongs to the first section that still has records left.
    always_comb begin
        if (r_an_left != 16'd0) begin
            sec_cur = SEC_ANSWER;
        end else if (r_ns_left != 16'd0) begin
            sec_cur = SEC_AUTHORITY;
        end else begin
            sec_cur = SEC_ADDITIONAL;
        end
    end

    // Next state and result for one byte.
    always_comb begin
        n_phase      = r_phase;
        n_cnt        = r_cnt;
        n_shift      = r_shift;
        n_q_left     = r_q_left;
        n_an_left    = r_an_left;
        n_ns_left    = r_ns_left;
        n_ar_left    = r_ar_left;
        n_data_left  = r_data_left;
        n_rec_idx    = r_rec_idx;
        n_ended      = r_ended;
        do_next      = 1'b0;
        do_rec_done  = 1'b0;
        do_restart   = 1'b0;
        rec_left_dec = 16'd0;
        res          = '0;
        res.status   = ST_OK;

        if (r_ended) begin
            // Trailing bytes are dropped until the last one.
            do_restart = i_last_byte;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    n_shift = assembled[23:0];
                    if (r_cnt[0]) begin
                        res.have        = 1'b1;
                        res.field_kind  = {1'b0, r_cnt[3:1]};
                        res.field_value = {16'd0, assembled[15:0]};
                        if (res.field_kind == KIND_QDCOUNT) begin
                            n_q_left = assembled[15:0];
                        end else if (res.field_kind == KIND_ANCOUNT) begin
                            n_an_left = assembled[15:0];
                        end else if (res.field_kind == KIND_NSCOUNT) begin
                            n_ns_left = assembled[15:0];
                        end else if (res.field_kind == KIND_ARCOUNT) begin
                            n_ar_left = assembled[15:0];
                        end
                    end
                    n_cnt = r_cnt + 4'd1;
                    if (n_cnt >= HEADER_BYTES) begin
                        if (n_q_left > i_max_questions) begin
                            res.status = ST_QUESTION_LIMIT;
                        end else if (n_an_left > i_max_records) begin
                            res.status = ST_ANSWER_LIMIT;
                        end else if (n_ns_left > i_max_records) begin
                            res.status = ST_AUTH_LIMIT;
                        end else if (n_ar_left > i_max_records) begin
                            res.status = ST_ADDL_LIMIT;
                        end
                        if (res.status != ST_OK) begin
                            res.message_done = 1'b1;
                        end else begin
                            do_next = 1'b1;
                        end
                    end
                end
                PH_QNAME: begin
                    if (i_data_byte == NAME_END) begin
                        n_phase = PH_QTYPE;
                        n_cnt   = 4'd0;
                        n_shift = 24'd0;
                    end else begin
                        res.have        = 1'b1;
                        res.field_kind  = KIND_NAME_BYTE;
                        res.item_index  = r_rec_idx;
                        res.field_value = {24'd0, i_data_byte};
                    end
                end
                PH_RDATA: begin
                    res.have        = 1'b1;
                    res.field_kind  = KIND_DATA_BYTE;
                    res.section     = sec_cur;
                    res.item_index  = r_rec_idx;
                    res.field_value = {24'd0, i_data_byte};
                    n_data_left     = r_data_left - 16'd1;
                    do_rec_done     = (n_data_left == 16'd0);
                end
                PH_QTYPE, PH_QCLASS, PH_RNAME, PH_RTYPE, PH_RCLASS, PH_RTTL,
                PH_RDLEN: begin
                    n_cnt   = r_cnt + 4'd1;
                    n_shift = assembled[23:0];
                    if (n_cnt >= {1'b0, need}) begin
                        res.have        = 1'b1;
                        res.item_index  = r_rec_idx;
                        res.field_value = (need == 3'd4) ? assembled
                                                         : {16'd0, assembled[15:0]};
                        res.section     = sec_cur;
                        n_cnt           = 4'd0;
                        n_shift         = 24'd0;
                        case (r_phase)
                            PH_QTYPE: begin
                                res.field_kind = KIND_QTYPE;
                                res.section    = SEC_QUESTION;
                                n_phase        = PH_QCLASS;
                            end
                            PH_QCLASS: begin
                                res.field_kind = KIND_QCLASS;
                                res.section    = SEC_QUESTION;
                                n_q_left       = r_q_left - 16'd1;
                                n_rec_idx      = (n_q_left == 16'd0) ? 16'd0
                                                                     : r_rec_idx + 16'd1;
                                do_next        = 1'b1;
                            end
                            PH_RNAME: begin
                                res.field_kind = KIND_RNAME;
                                n_phase        = PH_RTYPE;
                            end
                            PH_RTYPE: begin
                                res.field_kind = KIND_RTYPE;
                                n_phase        = PH_RCLASS;
                            end
                            PH_RCLASS: begin
                                res.field_kind = KIND_RCLASS;
                                n_phase        = PH_RTTL;
                            end
                            PH_RTTL: begin
                                res.field_kind = KIND_RTTL;
                                n_phase        = PH_RDLEN;
                            end
                            default: begin
                                res.field_kind = KIND_RDLEN;
                                n_data_left    = assembled[15:0];
                                if (assembled[15:0] == 16'd0) begin
                                    do_rec_done = 1'b1;
                                end else begin
                                    n_phase = PH_RDATA;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    do_restart = 1'b1;
                end
            endcase

            // A finished record takes one off its section's count.
            if (do_rec_done) begin
                if (r_an_left != 16'd0) begin
                    rec_left_dec = r_an_left - 16'd1;
                    n_an_left    = rec_left_dec;
                end else if (r_ns_left != 16'd0) begin
                    rec_left_dec = r_ns_left - 16'd1;
                    n_ns_left    = rec_left_dec;
                end else begin
                    rec_left_dec = r_ar_left - 16'd1;
                    n_ar_left    = rec_left_dec;
                end
                n_rec_idx = (rec_left_dec == 16'd0) ? 16'd0 : r_rec_idx + 16'd1;
                do_next   = 1'b1;
            end

            // Move on to the next question or record, or end the message.
            if (do_next) begin
                n_cnt   = 4'd0;
                n_shift = 24'd0;
                if (n_q_left != 16'd0) begin
                    n_phase = PH_QNAME;
                end else if (n_an_left != 16'd0 || n_ns_left != 16'd0 ||
                             n_ar_left != 16'd0) begin
                    n_phase = PH_RNAME;
                end else begin
                    res.message_done = 1'b1;
                end
            end

            // A last byte before the end of parsing marks truncation.
            if (!res.message_done && i_last_byte) begin
                res.status       = ST_TRUNCATED;
                res.message_done = 1'b1;
                if (!res.have) begin
                    res.field_kind  = KIND_ID;
                    res.section     = SEC_QUESTION;
                    res.item_index  = 16'd0;
                    res.field_value = 32'd0;
                end
                res.have = 1'b1;
            end
            if (res.message_done) begin
                n_ended = 1'b1;
            end
            if (i_last_byte) begin
                do_restart = 1'b1;
            end
        end

        // Every last byte starts the parser over at the header.
        if (do_restart) begin
            n_phase     = PH_HEADER;
            n_cnt       = 4'd0;
            n_shift     = 24'd0;
            n_q_left    = 16'd0;
            n_an_left   = 16'd0;
            n_ns_left   = 16'd0;
            n_ar_left   = 16'd0;
            n_data_left = 16'd0;
            n_rec_idx   = 16'd0;
            n_ended     = 1'b0;
        end
    end

    assign o_result = res;

    // Parser state advances on each processed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_cnt       <= 4'd0;
            r_shift     <= 24'd0;
            r_q_left    <= 16'd0;
            r_an_left   <= 16'd0;
            r_ns_left   <= 16'd0;
            r_ar_left   <= 16'd0;
            r_data_left <= 16'd0;
            r_rec_idx   <= 16'd0;
            r_ended     <= 1'b0;
        end else if (i_fire) begin
            r_phase     <= n_phase;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
            r_q_left    <= n_q_left;
            r_an_left   <= n_an_left;
            r_ns_left   <= n_ns_left;
            r_ar_left   <= n_ar_left;
            r_data_left <= n_data_left;
            r_rec_idx   <= n_rec_idx;
            r_ended     <= n_ended;
        end
    end

endmodule

// ----- design/dns_message_parser.sv -----
// Channel   Handshake                    Payload
// input     i_in_valid / o_in_ready      i_data_byte, i_last_byte
// output    o_out_valid / i_out_ready    o_field_kind, o_section, o_item_index,
//                                        o_field_value, o_status, o_message_done
// config    i_cfg_we                     i_cfg_index, i_cfg_data
//
// One byte is accepted per clock, sustained while the output is not stalled. A
// byte is captured in the input register when accepted and then parsed by the
// combinational core; its result, if any, is registered as the pipeline moves.
// Reset is synchronous and active low; configuration returns to 64 and 64.
// While the output register is held by a stall, an empty input register takes
// one more byte, and further bytes wait until the output transaction completes.
module dns_message_parser
    import dmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_field_kind,
    output logic [1:0]  o_section,
    output logic [15:0] o_item_index,
    output logic [31:0] o_field_value,
    output logic [2:0]  o_status,
    output logic        o_message_done,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0] r_max_questions;
    logic [15:0] r_max_records;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        r_out_valid;
    t_result     r_out;
    logic        advance;
    logic        fire;
    t_result     result;

    // Pipeline moves when the output register is empty or being drained.
    assign advance    = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_questions <= MAX_COUNT_RESET;
            r_max_records   <= MAX_COUNT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MAX_QUESTIONS) begin
                r_max_questions <= i_cfg_data;
            end else begin
                r_max_records <= i_cfg_data;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    dmp_parse_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_data_byte     (r_in_byte),
        .i_last_byte     (r_in_last),
        .i_max_questions (r_max_questions),
        .i_max_records   (r_max_records),
        .o_result        (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && result.have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_field_kind   = r_out.field_kind;
    assign o_section      = r_out.section;
    assign o_item_index   = r_out.item_index;
    assign o_field_value  = r_out.field_value;
    assign o_status       = r_out.status;
    assign o_message_done = r_out.message_done;

endmodule
